// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the sparse matvec block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SMVA_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
`define SMVA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SMVA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SMVA_ASSERT(label, cond)
`define SMVA_ASSERT_IMPL(label, ante, cons)
`define SMVA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/smva_pkg.sv =====
// ----------------------------------------------------------------------------
// smva_pkg
// shared types and constants of the sparse coo matvec accumulator
// ----------------------------------------------------------------------------
package smva_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;

  localparam int ROW_W = 10;
  localparam int COL_W = 10;
  localparam int VAL_W = 32;
  localparam int ACC_W = 48;
  localparam int PROD_W = 2 * VAL_W;
  localparam int FRAC_DROP = 16;
  localparam int CFG_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [CFG_W-1:0] NUM_ROWS_RESET = 11'd1024;
  localparam logic [CFG_W-1:0] NUM_COLS_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_NZ    = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_DISP,
    B_CLEAR,
    B_NZ_MUL,
    B_NZ_ACC,
    B_RD_OUT
  } back_state_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
    logic                     row_ok;
    logic                     col_ok;
  } q_item_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

// ===== sv/smva_front.sv =====
// ----------------------------------------------------------------------------
// smva_front
// configuration registers, input handshake and index range classification
// ----------------------------------------------------------------------------
module smva_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [smva_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smva_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_cmd,
  input  logic [smva_pkg::ROW_W-1:0]      in_row_index,
  input  logic [smva_pkg::COL_W-1:0]      in_col_index,
  input  logic signed [smva_pkg::VAL_W-1:0] in_value,
  input  logic                            q_full,
  input  smva_pkg::back_stat_t            stat,
  output logic                            q_push,
  output smva_pkg::q_item_t               q_item
);
  import smva_pkg::*;

  logic [CFG_W-1:0] num_rows_r, num_rows_nxt;
  logic [CFG_W-1:0] num_cols_r, num_cols_nxt;
  logic [CFG_W-1:0] rows_lim, cols_lim;

  assign cfg_ready = 1'b1;

  always_comb begin
    num_rows_nxt = num_rows_r;
    num_cols_nxt = num_cols_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_ROWS: num_rows_nxt = cfg_data;
        REG_NUM_COLS: num_cols_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= NUM_ROWS_RESET;
      num_cols_r <= NUM_COLS_RESET;
    end else begin
      num_rows_r <= num_rows_nxt;
      num_cols_r <= num_cols_nxt;
    end
  end

  // oversized bounds clamp to the store depth
  assign rows_lim = (num_rows_r > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : num_rows_r;
  assign cols_lim = (num_cols_r > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : num_cols_r;

  assign in_ready = !q_full && !stat.init_busy;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.cmd    = cmd_t'(in_cmd);
    q_item.row    = in_row_index;
    q_item.col    = in_col_index;
    q_item.value  = in_value;
    q_item.row_ok = CFG_W'(in_row_index) < rows_lim;
    q_item.col_ok = CFG_W'(in_col_index) < cols_lim;
  end

endmodule

// ===== sv/smva_queue.sv =====
// ----------------------------------------------------------------------------
// smva_queue
// short item queue between the front and back parts
// ----------------------------------------------------------------------------
module smva_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  smva_pkg::q_item_t  push_item,
  input  logic               pop,
  output smva_pkg::q_item_t  pop_item,
  output logic               full,
  output logic               empty
);
  import smva_pkg::*;

  q_item_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/smva_back.sv =====
// ----------------------------------------------------------------------------
// smva_back
// command execution: vector store, row accumulators, flags and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smva_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  input  smva_pkg::q_item_t                   q_item,
  output logic                                q_pop,
  output smva_pkg::back_stat_t                stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [smva_pkg::ROW_W-1:0]          out_row_out,
  output logic signed [smva_pkg::ACC_W-1:0]   out_row_sum,
  output logic                                out_range_error,
  output logic                                out_saturated
);
  import smva_pkg::*;

  logic signed [VAL_W-1:0] vec_mem [MAX_COLS];
  logic signed [ACC_W-1:0] acc_mem [MAX_ROWS];

  back_state_t             state_r, state_nxt;
  q_item_t                 cur_r, cur_nxt;
  logic [ROW_W-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                    rflag_r, rflag_nxt;
  logic                    sflag_r, sflag_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]        out_row_r, out_row_nxt;
  logic signed [ACC_W-1:0] out_sum_r, out_sum_nxt;
  logic                    out_rerr_r, out_rerr_nxt;
  logic                    out_sat_r, out_sat_nxt;

  logic signed [VAL_W-1:0] vec_rd_r;
  logic signed [ACC_W-1:0] acc_rd_r;

  logic                    vec_we, vec_re, acc_re, acc_we;
  logic [ROW_W-1:0]        acc_waddr;
  logic signed [ACC_W-1:0] acc_wdata;
  logic signed [ACC_W-1:0] prod_sh;
  logic signed [ACC_W:0]   sum_ext;
  logic                    ovf;

  // floor shift of the q32.32 product back to q32.16
  assign prod_sh = prod_r[PROD_W-1:FRAC_DROP];
  assign sum_ext = {acc_rd_r[ACC_W-1], acc_rd_r} + {prod_sh[ACC_W-1], prod_sh};
  assign ovf     = sum_ext[ACC_W] != sum_ext[ACC_W-1];

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    clr_cnt_nxt   = clr_cnt_r;
    prod_nxt      = prod_r;
    rflag_nxt     = rflag_r;
    sflag_nxt     = sflag_r;
    out_valid_nxt = out_valid_r;
    out_row_nxt   = out_row_r;
    out_sum_nxt   = out_sum_r;
    out_rerr_nxt  = out_rerr_r;
    out_sat_nxt   = out_sat_r;
    q_pop         = 1'b0;
    vec_we        = 1'b0;
    vec_re        = 1'b0;
    acc_re        = 1'b0;
    acc_we        = 1'b0;
    acc_waddr     = clr_cnt_r;
    acc_wdata     = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      B_INIT, B_CLEAR: begin
        acc_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ROW_W'(MAX_ROWS - 1)) begin
          clr_cnt_nxt = '0;
          state_nxt   = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          state_nxt = B_DISP;
        end
      end
      B_DISP: begin
        state_nxt = B_IDLE;
        case (cur_r.cmd)
          CMD_LOAD: begin
            if (cur_r.col_ok) begin
              vec_we = 1'b1;
            end else begin
              rflag_nxt = 1'b1;
            end
          end
          CMD_CLEAR: begin
            rflag_nxt   = 1'b0;
            sflag_nxt   = 1'b0;
            clr_cnt_nxt = '0;
            state_nxt   = B_CLEAR;
          end
          CMD_NZ: begin
            if (cur_r.row_ok && cur_r.col_ok) begin
              vec_re    = 1'b1;
              acc_re    = 1'b1;
              state_nxt = B_NZ_MUL;
            end else begin
              rflag_nxt = 1'b1;
            end
          end
          CMD_READ: begin
            acc_re    = 1'b1;
            state_nxt = B_RD_OUT;
            if (!cur_r.row_ok) begin
              rflag_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      B_NZ_MUL: begin
        prod_nxt  = vec_rd_r * $signed(cur_r.value);
        state_nxt = B_NZ_ACC;
      end
      B_NZ_ACC: begin
        acc_we    = 1'b1;
        acc_waddr = cur_r.row;
        acc_wdata = sum_ext[ACC_W-1:0];
        if (ovf) begin
          acc_wdata = sum_ext[ACC_W] ? ACC_MIN : ACC_MAX;
          sflag_nxt = 1'b1;
        end
        state_nxt = B_IDLE;
      end
      B_RD_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = cur_r.row;
          out_sum_nxt   = cur_r.row_ok ? acc_rd_r : '0;
          out_rerr_nxt  = rflag_r;
          out_sat_nxt   = sflag_r;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      clr_cnt_r   <= '0;
      rflag_r     <= 1'b0;
      sflag_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rflag_r     <= rflag_nxt;
      sflag_r     <= sflag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prod_r     <= prod_nxt;
    out_row_r  <= out_row_nxt;
    out_sum_r  <= out_sum_nxt;
    out_rerr_r <= out_rerr_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[cur_r.col] <= cur_r.value;
    end
    if (vec_re) begin
      vec_rd_r <= vec_mem[cur_r.col];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (acc_re) begin
      acc_rd_r <= acc_mem[cur_r.row];
    end
  end

  assign stat.init_busy  = (state_r == B_INIT);

  assign out_valid       = out_valid_r;
  assign out_row_out     = out_row_r;
  assign out_row_sum     = out_sum_r;
  assign out_range_error = out_rerr_r;
  assign out_saturated   = out_sat_r;

  `SMVA_ASSERT_NEXT(a_mul_then_acc, state_r == B_NZ_MUL, state_r == B_NZ_ACC)
  `SMVA_ASSERT_IMPL(a_acc_only_in_range, state_r == B_NZ_ACC, cur_r.row_ok && cur_r.col_ok)
  `SMVA_ASSERT_IMPL(a_pop_only_idle, q_pop, state_r == B_IDLE && !q_empty)

endmodule

// ===== sv/sparse_coo_matvec_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_coo_matvec_accumulator_unit
// sparse matrix times dense vector in coordinate form, q16.16 in, q32.16 sums
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
// in        in   in_valid/in_ready    in_cmd, in_row_index, in_col_index, in_value
// out       out  out_valid/out_ready  out_row_out, out_row_sum, out_range_error,
//                                     out_saturated
//
// items pass a two-entry queue into the execution fsm, one item at a time:
// load writes the vector store, nonzero reads, multiplies and accumulates, read row
// reads then outputs; clear sweeps the accumulators, one row zeroed per cycle
// after reset a sweep zeroes the accumulators, in_ready low
// a read row holds the fsm while the result register is still full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sparse_coo_matvec_accumulator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smva_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smva_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_cmd,
  input  logic [smva_pkg::ROW_W-1:0]          in_row_index,
  input  logic [smva_pkg::COL_W-1:0]          in_col_index,
  input  logic signed [smva_pkg::VAL_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [smva_pkg::ROW_W-1:0]          out_row_out,
  output logic signed [smva_pkg::ACC_W-1:0]   out_row_sum,
  output logic                                out_range_error,
  output logic                                out_saturated
);
  import smva_pkg::*;

  q_item_t    push_item, pop_item;
  logic       q_push, q_pop, q_full, q_empty;
  back_stat_t stat;

  smva_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_value     (in_value),
    .q_full       (q_full),
    .stat         (stat),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  smva_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  smva_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_out     (out_row_out),
    .out_row_sum     (out_row_sum),
    .out_range_error (out_range_error),
    .out_saturated   (out_saturated)
  );

  `SMVA_ASSERT_IMPL(a_no_accept_when_full, q_full || stat.init_busy, !in_ready)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sparse coo matvec accumulator unit
//
// A short directed table covers reset state, extreme Q16.16 products,
// saturation at both ends, floor truncation, out-of-range rows and columns,
// zero, oversized and unused register writes, and clear. It is followed by
// random matrix-vector products: vector loads, bursts of nonzeros on a few
// hot rows, row reads and some noise. Bounds change between phases. A
// predictor computes every row sum, and results are checked in order while
// both channels idle and stall in several patterns.
// ----------------------------------------------------------------------------
module tb;
  import smva_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int QUIET = MAX_ROWS + 128;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    cmd_t                    cmd;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } coo_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic signed [ACC_W-1:0] sum;
    logic                    range_err;
    logic                    sat;
  } row_report_t;

  typedef struct packed {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    coo_item_t            item;
    bit                   typed;
    row_report_t          want;
  } plan_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              in_cmd;
  logic [ROW_W-1:0]        in_row_index;
  logic [COL_W-1:0]        in_col_index;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [ROW_W-1:0]        out_row_out;
  logic signed [ACC_W-1:0] out_row_sum;
  logic                    out_range_error;
  logic                    out_saturated;

  // predictor state
  logic signed [VAL_W-1:0] vec_mem [MAX_COLS];
  logic signed [ACC_W-1:0] acc_mem [MAX_ROWS];
  bit                      range_flag;
  bit                      sat_flag;
  logic [CFG_W-1:0]        rows_reg = NUM_ROWS_RESET;
  logic [CFG_W-1:0]        cols_reg = NUM_COLS_RESET;
  bit                      col_loaded [MAX_COLS];
  int unsigned             loaded_cols[$];

  row_report_t awaited_sums[$];
  plan_row_t   plan[$];
  int          mismatches;
  int          items_sent;
  int          idle_pct;
  int          stall_pct;
  bit          hold_req;

  sparse_coo_matvec_accumulator_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_row_index    (in_row_index),
    .in_col_index    (in_col_index),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row_out     (out_row_out),
    .out_row_sum     (out_row_sum),
    .out_range_error (out_range_error),
    .out_saturated   (out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned bound_in_use(logic [CFG_W-1:0] r, int unsigned cap);
    return (r > cap) ? cap : r;
  endfunction

  function automatic void accumulate_item(input coo_item_t it, output bit has_sum,
                                          output row_report_t rep);
    bit     row_ok;
    bit     col_ok;
    longint prod;
    longint acc;
    row_ok = it.row < bound_in_use(rows_reg, MAX_ROWS);
    col_ok = it.col < bound_in_use(cols_reg, MAX_COLS);
    has_sum = 1'b0;
    rep = '0;
    case (it.cmd)
      CMD_LOAD: begin
        if (col_ok) begin
          vec_mem[it.col] = it.value;
          if (!col_loaded[it.col]) begin
            col_loaded[it.col] = 1'b1;
            loaded_cols.push_back(it.col);
          end
        end else begin
          range_flag = 1'b1;
        end
      end
      CMD_CLEAR: begin
        foreach (acc_mem[i]) acc_mem[i] = '0;
        range_flag = 1'b0;
        sat_flag = 1'b0;
      end
      CMD_NZ: begin
        if (row_ok && col_ok) begin
          // arithmetic shift floors towards minus infinity
          prod = (longint'($signed(it.value)) * longint'($signed(vec_mem[it.col])))
                 >>> FRAC_DROP;
          acc = longint'($signed(acc_mem[it.row])) + prod;
          if (acc > longint'(ACC_MAX)) begin
            acc = longint'(ACC_MAX);
            sat_flag = 1'b1;
          end else if (acc < longint'(ACC_MIN)) begin
            acc = longint'(ACC_MIN);
            sat_flag = 1'b1;
          end
          acc_mem[it.row] = acc[ACC_W-1:0];
        end else begin
          range_flag = 1'b1;
        end
      end
      CMD_READ: begin
        has_sum = 1'b1;
        rep.row = it.row;
        if (row_ok) rep.sum = acc_mem[it.row];
        else range_flag = 1'b1;
        rep.range_err = range_flag;
        rep.sat = sat_flag;
      end
      default: ;
    endcase
  endfunction

  function automatic plan_row_t item_row(cmd_t c, int unsigned r, int unsigned k,
                                         logic [VAL_W-1:0] v);
    plan_row_t p;
    p = '0;
    p.item.cmd = c;
    p.item.row = ROW_W'(r);
    p.item.col = COL_W'(k);
    p.item.value = v;
    return p;
  endfunction

  function automatic plan_row_t read_check_row(int unsigned r, logic signed [ACC_W-1:0] s,
                                               bit re, bit sa);
    plan_row_t p;
    p = item_row(CMD_READ, r, 0, '0);
    p.typed = 1'b1;
    p.want.row = ROW_W'(r);
    p.want.sum = s;
    p.want.range_err = re;
    p.want.sat = sa;
    return p;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.reg_idx = idx;
    p.reg_val = v;
    return p;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(7))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return VAL_W'($urandom_range(32'h7_ffff)) - 32'h4_0000;
    endcase
  endfunction

  function automatic int unsigned pick_index(int unsigned lim);
    case ($urandom_range(3))
      0: return 0;
      1: return lim - 1;
      default: return $urandom_range(lim - 1);
    endcase
  endfunction

  function automatic int unsigned any_loaded_col();
    return loaded_cols[$urandom_range(loaded_cols.size() - 1)];
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_item(coo_item_t it, bit typed, row_report_t want);
    bit          has_sum;
    row_report_t got;
    @(negedge clk);
    cfg_valid = 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = it.cmd;
    in_row_index = it.row;
    in_col_index = it.col;
    in_value = it.value;
    do @(posedge clk); while (!in_ready);
    accumulate_item(it, has_sum, got);
    if (has_sum) awaited_sums.push_back(typed ? want : got);
    items_sent++;
  endtask

  task automatic send_plain(cmd_t c, int unsigned r, int unsigned k, logic [VAL_W-1:0] v);
    plan_row_t p;
    p = item_row(c, r, k, v);
    send_item(p.item, 1'b0, '0);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_sums.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_NUM_ROWS) rows_reg = data;
    else if (idx == REG_NUM_COLS) cols_reg = data;
  endtask

  task automatic send_noise();
    case ($urandom_range(2))
      0: send_plain(CMD_LOAD, $urandom_range(MAX_ROWS - 1), $urandom_range(MAX_COLS - 1),
                    rand_value());
      1: send_plain(CMD_NZ, $urandom_range(MAX_ROWS - 1), any_loaded_col(), rand_value());
      default: send_plain(CMD_READ, $urandom_range(MAX_ROWS - 1), 0, '0);
    endcase
  endtask

  // one product: optional clear, vector loads, nonzeros on hot rows, reads, optional noise
  task automatic run_product();
    int unsigned      rb;
    int unsigned      cb;
    int unsigned      n;
    int unsigned      fresh[$];
    logic [ROW_W-1:0] hot_rows [3];
    rb = bound_in_use(rows_reg, MAX_ROWS);
    cb = bound_in_use(cols_reg, MAX_COLS);
    if ($urandom_range(3) == 0) send_plain(CMD_CLEAR, 0, 0, '0);
    n = $urandom_range(4, 1);
    repeat (n) begin
      fresh.push_back(pick_index(cb));
      send_plain(CMD_LOAD, 0, fresh[$], rand_value());
    end
    foreach (hot_rows[i]) hot_rows[i] = ROW_W'(pick_index(rb));
    n = $urandom_range(12, 2);
    repeat (n)
      send_plain(CMD_NZ, hot_rows[$urandom_range(2)],
                 ($urandom_range(7) == 0) ? any_loaded_col()
                                          : fresh[$urandom_range(fresh.size() - 1)],
                 rand_value());
    n = $urandom_range(4, 1);
    repeat (n)
      send_plain(CMD_READ, hot_rows[$urandom_range(2)], $urandom_range(MAX_COLS - 1),
                 rand_value());
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(3, 1);
      repeat (n) send_noise();
    end
  endtask

  task automatic run_phase(int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) run_product();
  endtask

  // result receiver
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    row_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_sums.size() == 0) begin
        report_mismatch($sformatf("row %0d reported with nothing awaited", out_row_out));
      end else begin
        want = awaited_sums.pop_front();
        if (out_row_out !== want.row)
          report_mismatch($sformatf("row_out %0d, want %0d", out_row_out, want.row));
        if (out_row_sum !== want.sum)
          report_mismatch($sformatf("row %0d sum %h, want %h", want.row, out_row_sum,
                                    want.sum));
        if (out_range_error !== want.range_err)
          report_mismatch($sformatf("row %0d range_error %b, want %b", want.row,
                                    out_range_error, want.range_err));
        if (out_saturated !== want.sat)
          report_mismatch($sformatf("row %0d saturated %b, want %b", want.row,
                                    out_saturated, want.sat));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("sparse_coo_matvec_accumulator_unit verification failed");
    $finish;
  end

  initial begin
    bit after_cfg;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_cmd = CMD_LOAD;
    in_row_index = '0;
    in_col_index = '0;
    in_value = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    after_cfg = 1'b0;
    foreach (acc_mem[i]) acc_mem[i] = '0;
    foreach (vec_mem[i]) vec_mem[i] = '0;

    plan = '{
      read_check_row(0, '0, 1'b0, 1'b0),
      read_check_row(MAX_ROWS - 1, '0, 1'b0, 1'b0),
      item_row(CMD_LOAD, 0, 0, 32'h8000_0000),
      item_row(CMD_LOAD, 0, MAX_COLS - 1, 32'h7fff_ffff),
      item_row(CMD_LOAD, 0, 1, 32'h0001_0000),
      item_row(CMD_LOAD, 0, 2, 32'h0000_8000),
      item_row(CMD_NZ, 0, 1, 32'h0002_0000),
      read_check_row(0, 48'sh2_0000, 1'b0, 1'b0),
      // minus one ulp times a half floors to minus one ulp
      item_row(CMD_NZ, 1, 2, 32'hffff_ffff),
      item_row(CMD_READ, 1, 0, '0),
      item_row(CMD_NZ, MAX_ROWS - 1, 0, 32'h8000_0000),
      item_row(CMD_NZ, MAX_ROWS - 1, 0, 32'h8000_0000),
      read_check_row(MAX_ROWS - 1, ACC_MAX, 1'b0, 1'b1),
      item_row(CMD_NZ, 2, MAX_COLS - 1, 32'h8000_0000),
      item_row(CMD_NZ, 2, MAX_COLS - 1, 32'h8000_0000),
      item_row(CMD_NZ, 2, MAX_COLS - 1, 32'h8000_0000),
      read_check_row(2, ACC_MIN, 1'b0, 1'b1),
      reg_row(REG_NUM_ROWS, 11'd4),
      reg_row(REG_NUM_COLS, 11'd3),
      read_check_row(4, '0, 1'b1, 1'b1),
      item_row(CMD_NZ, 0, MAX_COLS - 1, 32'h0000_0001),
      read_check_row(0, 48'sh2_0000, 1'b1, 1'b1),
      item_row(CMD_CLEAR, 0, 0, '0),
      read_check_row(3, '0, 1'b0, 1'b0),
      reg_row(REG_NUM_ROWS, 11'd0),
      reg_row(REG_NUM_COLS, 11'd0),
      reg_row(REG_UNUSED_2, 11'd5),
      reg_row(REG_UNUSED_3, 11'h7ff),
      item_row(CMD_LOAD, 0, 0, 32'h0000_0001),
      read_check_row(0, '0, 1'b1, 1'b0),
      item_row(CMD_CLEAR, 0, 0, '0)
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!after_cfg) settle();
        after_cfg = 1'b1;
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        after_cfg = 1'b0;
        send_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    // full bounds, no idling
    settle();
    write_reg(REG_NUM_ROWS, 11'd1024);
    write_reg(REG_NUM_COLS, 11'd1024);
    run_phase(230);

    // smallest bounds, sender mostly idle
    settle();
    write_reg(REG_NUM_ROWS, 11'd1);
    write_reg(REG_NUM_COLS, 11'd1);
    idle_pct = 79;
    run_phase(230);

    // oversized bounds, receiver mostly stalled, long hold-off up front
    settle();
    write_reg(REG_NUM_ROWS, 11'h7ff);
    write_reg(REG_NUM_COLS, 11'h7ff);
    idle_pct = 0;
    stall_pct = 79;
    hold_req = 1'b1;
    repeat (24) send_plain(CMD_READ, pick_index(MAX_ROWS), 0, '0);
    run_phase(200);

    // mid bounds, both sides idling, sender waits for every sum midway
    settle();
    write_reg(REG_NUM_ROWS, 11'd37);
    write_reg(REG_NUM_COLS, 11'd700);
    idle_pct = 24;
    stall_pct = 24;
    run_phase(115);
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_sums.size() != 0) @(posedge clk);
    run_phase(115);

    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_sums.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
    if (mismatches == 0) begin
      $display("sparse_coo_matvec_accumulator_unit verification clean");
    end else begin
      $display("sparse_coo_matvec_accumulator_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/smva_pkg.sv
sv/smva_front.sv
sv/smva_queue.sv
sv/smva_back.sv
sv/sparse_coo_matvec_accumulator_unit.sv
tb/tb.sv
